@@ rtl/bpe_pkg.sv @@
// Shared types and constants for the Bernstein polynomial evaluator.
package bpe_pkg;

  localparam int NCOEF      = 6;
  localparam int MAX_DEGREE = NCOEF - 1;
  localparam int DW         = 32;          // sample, register and result width
  localparam int FW         = 32;          // fraction bits of t
  localparam int TW         = FW + 1;      // t spans 0 .. 1.0 inclusive
  localparam int CFG_IW     = 3;

  typedef logic signed [DW-1:0] word_t;
  typedef logic [TW-1:0]        frac_t;
  typedef word_t                coef_arr_t [NCOEF];

  localparam frac_t T_ONE = {1'b1, {FW{1'b0}}};

  typedef enum logic [CFG_IW-1:0] {
    REG_X_MIN      = 3'd0,
    REG_INV_RANGE  = 3'd1,
    REG_COEF_ZERO  = 3'd2,
    REG_COEF_ONE   = 3'd3,
    REG_COEF_TWO   = 3'd4,
    REG_COEF_THREE = 3'd5,
    REG_COEF_FOUR  = 3'd6,
    REG_COEF_FIVE  = 3'd7
  } cfg_reg_t;

endpackage

@@ rtl/bpe_in_if.sv @@
// Sample channel: valid/ready handshake carrying one sample per beat.
interface bpe_in_if;
  logic              valid;
  logic              ready;
  bpe_pkg::word_t    sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink   (input valid, input sample_x, output ready);
endinterface

@@ rtl/bpe_out_if.sv @@
// Result channel: valid/ready handshake carrying one polynomial value per beat.
interface bpe_out_if;
  logic              valid;
  logic              ready;
  bpe_pkg::word_t    poly_value;
  logic              clamped;

  modport source (output valid, output poly_value, output clamped, input ready);
  modport sink   (input valid, input poly_value, input clamped, output ready);
endinterface

@@ rtl/bpe_norm.sv @@
// Three-stage normaliser: subtract, scale by the reciprocal, clamp t to [0,1].
module bpe_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpe_pkg::word_t     sample_x,
  input  bpe_pkg::word_t     x_min,
  input  logic [31:0]        inv_range,
  output logic               out_valid,
  input  logic               out_ready,
  output bpe_pkg::frac_t     t_out,
  output logic               clamp_out
);

  logic                      v1_r, v2_r, v3_r;
  logic                      en1, en2, en3;
  logic signed [32:0]        d1_r;
  logic                      inz1_r;
  logic [63:0]               prod;
  logic [63:0]               p2_r;
  logic                      neg2_r;
  logic                      over;
  bpe_pkg::frac_t            t3_r;
  logic                      cl3_r;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Product of the positive difference and the reciprocal: exact Q.32.
  assign prod = 64'(d1_r[31:0]) * 64'(inv_range);
  assign over = (p2_r[63:32] > 32'd1) || (p2_r[32] && (|p2_r[31:0]));

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r   <= {sample_x[31], sample_x} - {x_min[31], x_min};
      inz1_r <= |inv_range;
    end
    if (en2) begin
      neg2_r <= d1_r[32] && inz1_r;
      p2_r   <= d1_r[32] ? 64'd0 : prod;
    end
    if (en3) begin
      t3_r  <= over ? bpe_pkg::T_ONE : p2_r[32:0];
      cl3_r <= neg2_r || over;
    end
  end

  assign out_valid = v3_r;
  assign t_out     = t3_r;
  assign clamp_out = cl3_r;

endmodule

@@ rtl/bpe_round.sv @@
// One de Casteljau round: difference, multiply by t, round and add back.
module bpe_round #(
  parameter int NOUT = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bpe_pkg::coef_arr_t    b_in,
  input  bpe_pkg::frac_t        t_in,
  input  logic                  clamp_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpe_pkg::coef_arr_t    b_out,
  output bpe_pkg::frac_t        t_out,
  output logic                  clamp_out
);

  logic                      va_r, vb_r, vc_r;
  logic                      ena, enb, enc;
  logic signed [32:0]        diff_a_r [NOUT];
  bpe_pkg::word_t            base_a_r [NOUT];
  bpe_pkg::frac_t            t_a_r, t_b_r, t_c_r;
  logic                      cl_a_r, cl_b_r, cl_c_r;
  logic signed [66:0]        mul_b    [NOUT];
  logic signed [65:0]        prod_b_r [NOUT];
  bpe_pkg::word_t            base_b_r [NOUT];
  logic signed [33:0]        sum_c    [NOUT];
  bpe_pkg::word_t            b_c_r    [NOUT];

  assign enc      = !vc_r || out_ready;
  assign enb      = !vb_r || enc;
  assign ena      = !va_r || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ena) va_r <= in_valid;
      if (enb) vb_r <= va_r;
      if (enc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      t_a_r  <= t_in;
      cl_a_r <= clamp_in;
    end
    if (enb) begin
      t_b_r  <= t_a_r;
      cl_b_r <= cl_a_r;
    end
    if (enc) begin
      t_c_r  <= t_b_r;
      cl_c_r <= cl_b_r;
    end
  end

  // b*(1-t) + b_next*t == b + (b_next - b)*t, so one multiplier per lane.
  for (genvar k = 0; k < NOUT; k++) begin : g_lane
    assign mul_b[k] = diff_a_r[k] * $signed({1'b0, t_a_r});
    assign sum_c[k] = $signed({{2{base_b_r[k][31]}}, base_b_r[k]})
                    + $signed(prod_b_r[k][65:32])
                    + $signed({33'd0, prod_b_r[k][31]});

    always_ff @(posedge clk) begin
      if (ena) begin
        diff_a_r[k] <= {b_in[k+1][31], b_in[k+1]} - {b_in[k][31], b_in[k]};
        base_a_r[k] <= b_in[k];
      end
      if (enb) begin
        prod_b_r[k] <= mul_b[k][65:0];
        base_b_r[k] <= base_a_r[k];
      end
      if (enc) begin
        b_c_r[k] <= sum_c[k][31:0];
      end
    end

    assign b_out[k] = b_c_r[k];
  end

  for (genvar k = NOUT; k < bpe_pkg::NCOEF; k++) begin : g_idle
    assign b_out[k] = '0;
  end

  assign out_valid = vc_r;
  assign t_out     = t_c_r;
  assign clamp_out = cl_c_r;

endmodule

@@ rtl/bernstein_polynomial_eval_top.sv @@
// Top level of the Bernstein polynomial evaluator.
//
// Usage: write x_min, inv_range and the coefficients through the cfg_ port
// (cfg_wr_en, cfg_index, cfg_wdata; one register per cycle, no read-back)
// while no sample is in flight. Samples then enter on in_stream, one per
// beat; each produces exactly one beat on out_stream carrying poly_value
// (signed Q8.24) and clamped (t fell outside [0,1] and was pinned).
//
// Throughput: one sample per cycle while out_stream.ready is high. Three
// stages normalise x to t; each of the degree de Casteljau rounds takes three
// stages (difference, 33x34 multiply, round and add), one multiplier per lane.
//
// Reset (rst_n low at a clock edge) empties the pipeline and returns the
// registers to x_min = 0, inv_range = 1.0 and all coefficients zero.
// When out_stream.ready is low, each stage holds only once the stage after it
// is full, so bubbles close up and in_stream.ready falls only when every stage
// holds a sample. Nothing is dropped or repeated.
module bernstein_polynomial_eval_top #(
  parameter int POLY_DEGREE = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bpe_in_if.sink                            in_stream,
  bpe_out_if.source                         out_stream,
  input  logic                              cfg_wr_en,
  input  logic [bpe_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [bpe_pkg::DW-1:0]            cfg_wdata
);

  // Degrees above the supported maximum are treated as the maximum.
  localparam int DEG = (POLY_DEGREE > bpe_pkg::MAX_DEGREE) ? bpe_pkg::MAX_DEGREE :
                       (POLY_DEGREE < 0) ? 0 : POLY_DEGREE;

  bpe_pkg::word_t            x_min_r;
  logic [bpe_pkg::DW-1:0]    inv_range_r;
  bpe_pkg::coef_arr_t        coef_r;

  // Stage boundary buses: index 0 is the normaliser output.
  bpe_pkg::coef_arr_t        b_bus  [DEG+1];
  bpe_pkg::frac_t            t_bus  [DEG+1];
  logic                      v_bus  [DEG+1];
  logic                      r_bus  [DEG+1];
  logic                      cl_bus [DEG+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r     <= '0;
      inv_range_r <= 32'd65536;
      for (int i = 0; i < bpe_pkg::NCOEF; i++) coef_r[i] <= '0;
    end else if (cfg_wr_en) begin
      case (bpe_pkg::cfg_reg_t'(cfg_index))
        bpe_pkg::REG_X_MIN:      x_min_r     <= cfg_wdata;
        bpe_pkg::REG_INV_RANGE:  inv_range_r <= cfg_wdata;
        bpe_pkg::REG_COEF_ZERO:  coef_r[0]   <= cfg_wdata;
        bpe_pkg::REG_COEF_ONE:   coef_r[1]   <= cfg_wdata;
        bpe_pkg::REG_COEF_TWO:   coef_r[2]   <= cfg_wdata;
        bpe_pkg::REG_COEF_THREE: coef_r[3]   <= cfg_wdata;
        bpe_pkg::REG_COEF_FOUR:  coef_r[4]   <= cfg_wdata;
        bpe_pkg::REG_COEF_FIVE:  coef_r[5]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpe_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .sample_x  (in_stream.sample_x),
    .x_min     (x_min_r),
    .inv_range (inv_range_r),
    .out_valid (v_bus[0]),
    .out_ready (r_bus[0]),
    .t_out     (t_bus[0]),
    .clamp_out (cl_bus[0])
  );

  // Coefficients must be kept static by the user while samples are in flight
  // (the block does not enforce it), so feed them straight into the first round.
  assign b_bus[0] = coef_r;

  for (genvar r = 1; r <= DEG; r++) begin : g_round
    bpe_round #(
      .NOUT (DEG - r + 1)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_bus[r-1]),
      .in_ready  (r_bus[r-1]),
      .b_in      (b_bus[r-1]),
      .t_in      (t_bus[r-1]),
      .clamp_in  (cl_bus[r-1]),
      .out_valid (v_bus[r]),
      .out_ready (r_bus[r]),
      .b_out     (b_bus[r]),
      .t_out     (t_bus[r]),
      .clamp_out (cl_bus[r])
    );
  end

  // The last stage register is the output register.
  assign out_stream.valid      = v_bus[DEG];
  assign r_bus[DEG]            = out_stream.ready;
  assign out_stream.poly_value = b_bus[DEG][0];
  assign out_stream.clamped    = cl_bus[DEG];

  // A pinned t is exactly 0 or 1, so the value is an end coefficient.
  a_clamp_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && out_stream.clamped) |->
      (out_stream.poly_value == coef_r[0] || out_stream.poly_value == coef_r[DEG]))
    else $error("clamped result is not an end coefficient");

  // Back-pressure at the input only arises from a full, stalled pipeline.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stream.ready |-> (out_stream.valid && !out_stream.ready))
    else $error("input stalled without output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_stream.valid)
    else $error("output valid straight after reset");

endmodule

@@ sim/tb_bernstein_polynomial_eval_top.sv @@
// Self-checking testbench for the Bernstein polynomial evaluator top level.
module tb_bernstein_polynomial_eval_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLY_DEGREE  = 5;
  // Input beat to output beat, three normalising stages plus three per round
  localparam int PIPE_LATENCY = 3 + 3 * POLY_DEGREE;
  localparam int RANDOM_ITEMS = 850;
  localparam int NUM_PHASES   = 8;
  localparam int PRESSURE_RUN = 120;  // gapless beats offered while the sink holds off
  localparam int HOLDOFF_LEN  = 80;   // well beyond the pipeline depth
  localparam longint TIMEOUT_NS = 1_000_000;

  localparam bpe_pkg::word_t Q24_MAX = 32'sh7FFF_FFFF;
  localparam bpe_pkg::word_t Q24_MIN = 32'sh8000_0000;

  typedef struct packed {
    bpe_pkg::word_t poly_value;
    logic           clamped;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One row of the directed walk: either a register write or a sample. Rows with
  // known set carry the result that can be read straight off the settings.
  typedef struct packed {
    row_kind_t         kind;
    bpe_pkg::cfg_reg_t reg_sel;
    bpe_pkg::word_t    value;
    logic              known;
    bpe_pkg::word_t    want_value;
    logic              want_clamped;
  } stim_row_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  bpe_pkg::cfg_reg_t cfg_index;
  bpe_pkg::word_t    cfg_wdata;

  bpe_in_if    in_stream ();
  bpe_out_if   out_stream ();

  bernstein_polynomial_eval_top #(
    .POLY_DEGREE (POLY_DEGREE)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .out_stream (out_stream),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the register file, updated at the same edge as the block's own copy
  bpe_pkg::word_t range_lo;
  logic [31:0]    range_recip;
  bpe_pkg::word_t coef_shadow [bpe_pkg::NCOEF];

  // Results still owed by the block, oldest first
  result_t     expected_values [$];
  result_t     oldest;
  int          samples_sent = 0;
  int          values_seen  = 0;
  int          mismatches   = 0;

  // Directed rows hand their typed result over with the sample beat
  logic           known_next;
  bpe_pkg::word_t known_value;
  logic           known_clamped;

  // The sender asks the sink for a long hold-off by bumping this count
  int          holdoff_asked = 0;
  int          holdoff_done  = 0;

  // Range the current phase was configured for, used to aim random samples
  longint      window_lo;
  longint      window_w;

  // --------------------------------------------------------------------------
  // Predictor: map x to the exact Q1.32 position, clamp, then run de Casteljau
  // rounds over the shadow coefficients with half-up rounding at every blend.
  // --------------------------------------------------------------------------
  function automatic result_t bernstein_at(bpe_pkg::word_t x);
    longint          offset;
    logic [63:0]     prod;
    bpe_pkg::frac_t  t;
    bpe_pkg::frac_t  s;
    longint          blend [bpe_pkg::NCOEF];
    longint          acc;
    int              deg;
    result_t         r;

    deg = (POLY_DEGREE > bpe_pkg::MAX_DEGREE) ? bpe_pkg::MAX_DEGREE : POLY_DEGREE;
    if (deg < 0) deg = 0;

    // 33-bit exact difference; a zero reciprocal pins t at zero without the flag
    offset    = longint'(x) - longint'(range_lo);
    r.clamped = 1'b0;
    t         = '0;
    if (offset == 0 || range_recip == '0) begin
      t = '0;
    end else if (offset < 0) begin
      t         = '0;
      r.clamped = 1'b1;
    end else begin
      prod = 64'(offset) * 64'(range_recip);
      if (prod > 64'h1_0000_0000) begin
        t         = bpe_pkg::T_ONE;
        r.clamped = 1'b1;
      end else begin
        t = prod[bpe_pkg::TW-1:0];
      end
    end
    s = bpe_pkg::T_ONE - t;

    for (int i = 0; i < bpe_pkg::NCOEF; i++) blend[i] = longint'(coef_shadow[i]);
    // Each blend is convex, so the 64-bit accumulator cannot overflow
    for (int rd = 1; rd <= deg; rd++) begin
      for (int i = 0; i <= deg - rd; i++) begin
        acc      = blend[i] * longint'(s) + blend[i+1] * longint'(t);
        blend[i] = (acc + 64'sh8000_0000) >>> bpe_pkg::FW;
      end
    end
    r.poly_value = bpe_pkg::word_t'(blend[0]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: retire the output beat first, then log the input beat, then
  // track register writes. All of it reads pre-edge values only.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      range_lo    = '0;
      range_recip = 32'h0001_0000;
      for (int i = 0; i < bpe_pkg::NCOEF; i++) coef_shadow[i] = '0;
    end else begin
      if (out_stream.valid && out_stream.ready) begin
        values_seen++;
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected beat, poly_value %h clamped %b",
                   $time, out_stream.poly_value, out_stream.clamped);
          mismatches++;
        end else begin
          oldest = expected_values.pop_front();
          if (out_stream.poly_value !== oldest.poly_value) begin
            $display("%0t: poly_value expected %h actual %h",
                     $time, oldest.poly_value, out_stream.poly_value);
            mismatches++;
          end
          if (out_stream.clamped !== oldest.clamped) begin
            $display("%0t: clamped expected %b actual %b",
                     $time, oldest.clamped, out_stream.clamped);
            mismatches++;
          end
        end
      end
      if (in_stream.valid && in_stream.ready) begin
        if (known_next)
          expected_values.push_back(result_t'{known_value, known_clamped});
        else
          expected_values.push_back(bernstein_at(in_stream.sample_x));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          bpe_pkg::REG_X_MIN:     range_lo    = cfg_wdata;
          bpe_pkg::REG_INV_RANGE: range_recip = cfg_wdata;
          default: coef_shadow[cfg_index - bpe_pkg::REG_COEF_ZERO] = cfg_wdata;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one sample and hold it until the beat is taken. Valid is left high;
  // the caller drops it when a gap follows.
  task automatic offer_sample(bpe_pkg::word_t x, logic known, bpe_pkg::word_t want_v,
                              logic want_c);
    in_stream.valid    <= 1'b1;
    in_stream.sample_x <= x;
    known_next         <= known;
    known_value        <= want_v;
    known_clamped      <= want_c;
    do @(posedge clk); while (!in_stream.ready);
    samples_sent++;
  endtask

  // Hold until every sample offered so far has come back out
  task automatic wait_drained();
    wait (values_seen == samples_sent);
    @(posedge clk);
  endtask

  // Write enable stays high; the caller lowers it after the last write of a group
  task automatic write_reg(bpe_pkg::cfg_reg_t sel, bpe_pkg::word_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  function automatic bpe_pkg::word_t pick_coef();
    case ($urandom_range(0, 5))
      0:       return Q24_MAX;
      1:       return Q24_MIN;
      default: return bpe_pkg::word_t'($urandom);
    endcase
  endfunction

  // Aim mostly inside the configured range, with its ends, near misses just
  // outside and some fully random samples that exercise every bit.
  function automatic bpe_pkg::word_t pick_sample();
    longint cand;
    int     pick;

    pick = $urandom_range(0, 99);
    if (pick < 10)
      cand = longint'(int'($urandom));
    else if (pick < 16)
      cand = ($urandom_range(0, 1) != 0) ? window_lo : window_lo + window_w;
    else if (pick < 20)
      cand = window_lo - longint'($urandom_range(1, 32'(window_w / 8) + 1));
    else if (pick < 24)
      cand = window_lo + window_w + longint'($urandom_range(1, 32'(window_w / 8) + 1));
    else
      cand = window_lo + longint'($urandom_range(0, 32'(window_w)));
    if (cand < -64'sd2147483648 || cand > 64'sd2147483647)
      cand = longint'(int'($urandom));
    return bpe_pkg::word_t'(cand);
  endfunction

  // Set the range and all six coefficients for one random phase. The first
  // phases and the last one sit on the extremes of the range registers.
  task automatic configure_phase(int ph);
    longint      lo;
    longint      w;
    logic [31:0] recip;

    if (ph == 0) begin
      lo    = -64'sd2147483648;
      recip = 32'hFFFF_FFFF;
      w     = 1;
    end else if (ph == 1) begin
      lo    = -64'sd1073741824;
      recip = 32'h0000_0001;
      w     = 64'sd2147483648;
    end else if (ph == NUM_PHASES - 1) begin
      lo    = 64'sd2147483647;
      recip = '0;
      w     = 1;
    end else begin
      w = longint'($urandom_range(2, 32'h7FFF_FFFF)) >> $urandom_range(0, 30);
      if (w < 2) w = 2;
      recip = 32'(64'h1_0000_0000 / w);
      lo    = longint'(int'($urandom));
      if (lo + w > 64'sd2147483647) lo = 64'sd2147483647 - w;
    end
    window_lo = lo;
    window_w  = w;
    write_reg(bpe_pkg::REG_X_MIN, bpe_pkg::word_t'(lo));
    write_reg(bpe_pkg::REG_INV_RANGE, recip);
    for (int i = 0; i < bpe_pkg::NCOEF; i++)
      write_reg(bpe_pkg::cfg_reg_t'(bpe_pkg::REG_COEF_ZERO + i), pick_coef());
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed walk. Rows with a typed result are the ones whose answer is plain:
  // zero coefficients, t exactly 0 (gives c0), t exactly 1 (gives c5), clamped
  // either side, a zero reciprocal, and coefficients that are all equal.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [$] = '{
    // reset settings: coefficients zero, range [0,1]
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1},
    // mixed coefficients, c0 at the top of the range and c5 at the bottom
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ZERO,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ONE,   32'h0100_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_TWO,   32'hFF00_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_THREE, 32'h0080_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FOUR,  32'hC000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FIVE,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0001_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0001_0001, 1'b1, 32'h8000_0000, 1'b1},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_8000, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_FFFF, 1'b0, 32'h0,         1'b0},
    // lowest x_min with the largest reciprocal: one step lands just short of 1
    '{ROW_WRITE,  bpe_pkg::REG_X_MIN,      32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_INV_RANGE,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0002, 1'b1, 32'h8000_0000, 1'b1},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1},
    // zero reciprocal: t stays at zero and never flags
    '{ROW_WRITE,  bpe_pkg::REG_INV_RANGE,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // highest x_min with the smallest reciprocal: everything below clamps
    '{ROW_WRITE,  bpe_pkg::REG_X_MIN,      32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_INV_RANGE,  32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // equal coefficients at the top: every blend returns the same value
    '{ROW_WRITE,  bpe_pkg::REG_X_MIN,      32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_INV_RANGE,  32'h0001_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ZERO,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ONE,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_TWO,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_THREE, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FOUR,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FIVE,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_4000, 1'b1, 32'h7FFF_FFFF, 1'b0},
    // equal coefficients at the bottom
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ZERO,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_ONE,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_TWO,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_THREE, 32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FOUR,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_WRITE,  bpe_pkg::REG_COEF_FIVE,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0000_C000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_SAMPLE, bpe_pkg::REG_X_MIN,      32'h0002_0000, 1'b1, 32'h8000_0000, 1'b1}
  };

  // --------------------------------------------------------------------------
  // Sender: reset, directed walk, then random phases in bursts with gaps.
  // Registers change only once the pipeline has emptied.
  // --------------------------------------------------------------------------
  initial begin
    int        sent;
    int        quota;
    int        burst;
    logic      writing;
    stim_row_t row;

    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= bpe_pkg::REG_X_MIN;
    cfg_wdata          <= '0;
    in_stream.valid    <= 1'b0;
    in_stream.sample_x <= '0;
    known_next         <= 1'b0;
    known_value        <= '0;
    known_clamped      <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; a run of write rows drains the pipeline first
    writing = 1'b0;
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          in_stream.valid <= 1'b0;
          wait_drained();
          writing = 1'b1;
        end
        write_reg(row.reg_sel, row.value);
      end else begin
        if (writing) begin
          cfg_wr_en <= 1'b0;
          writing = 1'b0;
        end
        offer_sample(row.value, row.known, row.want_value, row.want_clamped);
      end
    end

    // Random phases; two of them open with a long gapless run while the
    // sink holds off, so the pipeline fills and back-pressures the input
    quota = RANDOM_ITEMS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_stream.valid <= 1'b0;
      wait_drained();
      configure_phase(ph);
      sent = 0;
      if (ph == 2 || ph == 5) begin
        holdoff_asked <= holdoff_asked + 1;
        repeat (PRESSURE_RUN) begin
          offer_sample(pick_sample(), 1'b0, '0, 1'b0);
          sent++;
        end
      end
      while (sent < quota) begin
        burst = $urandom_range(1, 24);
        if (burst > quota - sent) burst = quota - sent;
        repeat (burst) begin
          offer_sample(pick_sample(), 1'b0, '0, 1'b0);
          sent++;
        end
        // Sometimes run straight into the next burst, otherwise drop valid
        if ($urandom_range(0, 3) != 0) begin
          in_stream.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    // Drain, then watch a little longer for any stray beats
    in_stream.valid <= 1'b0;
    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink: stretches of always-ready, coin-flip and sparse ready, plus the long
  // hold-offs the sender asks for.
  // --------------------------------------------------------------------------
  initial begin
    ready_mode_t mode;
    int          len;

    out_stream.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holdoff_asked != holdoff_done) begin
        out_stream.ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk);
        holdoff_done++;
      end else begin
        mode = ready_mode_t'($urandom_range(0, 2));
        len  = $urandom_range(5, 40);
        repeat (len) begin
          case (mode)
            READY_ALWAYS: out_stream.ready <= 1'b1;
            READY_COIN:   out_stream.ready <= 1'($urandom_range(0, 1));
            default:      out_stream.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d results outstanding", $time, expected_values.size());
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bpe_pkg.sv
rtl/bpe_in_if.sv
rtl/bpe_out_if.sv
rtl/bpe_norm.sv
rtl/bpe_round.sv
rtl/bernstein_polynomial_eval_top.sv
sim/tb_bernstein_polynomial_eval_top.sv
